FILE: design/pwm_capture_measure_top_defines.svh
// Assertion macros for the capture measurement top level.
`ifndef PWM_CAPTURE_MEASURE_TOP_DEFINES_SVH
`define PWM_CAPTURE_MEASURE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PWMCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PWMCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pwmcm_pkg.sv
// Types and constants of the PWM capture measurement block.
`default_nettype none
package pwmcm_pkg;

  localparam int CAP_W      = 16;
  localparam int OVF_W      = 16;
  localparam int STAMP_W    = 32;
  localparam int DUTY_W     = 7;
  localparam int FREQ_W     = 24;
  localparam int PROD_W     = STAMP_W + DUTY_W;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 2;

  localparam logic [DUTY_W-1:0] DUTY_SCALE    = 7'd100;
  localparam logic [FREQ_W-1:0] TICK_RATE_RST = 24'd250000;

  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_START,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               arm;
    logic               done;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] high;
  } stamp_res_t;

endpackage
`default_nettype wire

FILE: design/pwm_capture_measure_top.sv
// Top level of the PWM capture measurement block.
// Usage:
//   in_*  : one item per transfer; in_tuser is the kind (0 overflow tick,
//           1 capture), in_tdata the captured timer count.
//   out_* : exactly one result per input item, in order, held in an output
//           register until out_tready takes it.
//   cfg_* : write of the tick rate (Hz), taken on any cycle with cfg_wr_en.
// Flow: an overflow tick or a first or second capture goes from its transfer
//   through S_EVAL straight to S_EMIT. A third capture runs the period through
//   two bit-serial dividers side by side (duty over 39 bits, frequency over
//   24), by way of S_MUL, S_START and S_DIV; the 39-step duty divider is the
//   one that finishes last. A zero period skips the dividers.
// Input flow: one item at a time; in_tready rises again once the result is in
//   the output register, so a new item may enter while it waits.
// Reset: rst_n low clears the phase, the overflow count and the stamps, sets
//   the tick rate to 250000 and empties the output register.
// Stall: while out_tready is low the result holds; at most one further item
//   is taken and then waits until the register frees.
`default_nettype none
`include "pwm_capture_measure_top_defines.svh"
module pwm_capture_measure_top #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pwmcm_pkg::FREQ_W-1:0]     cfg_wr_data,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // capture_value [15:0]
  input  wire logic [pwmcm_pkg::CAP_W-1:0]      in_tdata,
  // action [0]
  input  wire logic [0:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // arm_falling_edge [0], period_ticks [32:1], high_ticks [64:33],
  // duty_percent [71:65], frequency_hz [95:72]
  output logic [pwmcm_pkg::OUT_DATA_W-1:0]      out_tdata,
  // measurement_done [0], bad_period [1]
  output logic [pwmcm_pkg::OUT_USER_W-1:0]      out_tuser
);
  import pwmcm_pkg::*;

  state_t              state_r, state_nxt;
  logic [FREQ_W-1:0]   tick_rate_r;
  logic [PROD_W-1:0]   prod_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  stamp_res_t          stamp_res;
  logic                accept;
  logic                div_start;
  logic                load_out;
  logic                out_free;
  logic                duty_busy;
  logic                freq_busy;
  logic [PROD_W-1:0]   duty_q;
  logic [FREQ_W-1:0]   freq_q;
  logic                zero_period;
  logic                bad;
  logic [DUTY_W-1:0]   duty;
  logic [FREQ_W-1:0]   freq;

  assign accept      = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign zero_period = (stamp_res.period == '0);

  pwmcm_stamp #(
    .TIMER_BITS(TIMER_BITS)
  ) u_stamp (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .action       (in_tuser[0]),
    .capture_value(in_tdata),
    .res          (stamp_res)
  );

  pwmcm_div #(
    .NW(PROD_W),
    .DW(STAMP_W)
  ) u_duty_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(prod_r),
    .divisor (stamp_res.period),
    .busy    (duty_busy),
    .quotient(duty_q)
  );

  pwmcm_div #(
    .NW(FREQ_W),
    .DW(STAMP_W)
  ) u_freq_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(tick_rate_r),
    .divisor (stamp_res.period),
    .busy    (freq_busy),
    .quotient(freq_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = (stamp_res.done && !zero_period) ? S_MUL : S_EMIT;
      S_MUL:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (!duty_busy && !freq_busy) state_nxt = S_EMIT;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_START: div_start = 1'b1;
      S_EMIT:  load_out  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    bad  = stamp_res.done && zero_period;
    duty = '0;
    freq = '0;
    if (stamp_res.done && !zero_period) begin
      duty = (duty_q > PROD_W'(DUTY_SCALE)) ? DUTY_SCALE : duty_q[DUTY_W-1:0];
      freq = freq_q;
    end
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (load_out) begin
      out_data_nxt  = {freq, duty, stamp_res.high, stamp_res.period, stamp_res.arm};
      out_user_nxt  = {bad, stamp_res.done};
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tick_rate_r <= TICK_RATE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tick_rate_r <= cfg_wr_data;
      end
    end
    prod_r     <= PROD_W'(stamp_res.high) * PROD_W'(DUTY_SCALE);
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `PWMCM_ASSERT_NEXT(a_busy_after_transfer, accept, !in_tready,
    "input accepted while an item is still in work")
  `PWMCM_ASSERT_NEXT(a_div_to_emit, (state_r == S_DIV) && !duty_busy && !freq_busy,
    state_r == S_EMIT, "divider finish did not lead to result load")
  `PWMCM_ASSERT_NEXT(a_bad_zeroes, load_out && stamp_res.done && zero_period,
    out_tuser[1] && (out_tdata[71:65] == '0) && (out_tdata[95:72] == '0),
    "zero period result not forced to zero")
  `PWMCM_ASSERT_NOW(a_idle_result_zero, out_tvalid && !out_tuser[0],
    (out_tdata[64:1] == '0) && !out_tuser[1],
    "result without measurement carries tick values")

endmodule
`default_nettype wire

FILE: design/pwmcm_stamp.sv
// Capture front end: overflow count, timestamps, edge phase and tick deltas.
`default_nettype none
module pwmcm_stamp #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic                       action,
  input  wire logic [pwmcm_pkg::CAP_W-1:0] capture_value,
  output pwmcm_pkg::stamp_res_t           res
);
  import pwmcm_pkg::*;

  localparam logic [CAP_W-1:0] CAP_MASK = (TIMER_BITS >= CAP_W) ? {CAP_W{1'b1}} :
                                          CAP_W'((64'd1 << TIMER_BITS) - 64'd1);

  phase_t             phase_r, phase_nxt;
  logic [OVF_W-1:0]   ovf_r, ovf_nxt;
  logic [STAMP_W-1:0] first_r, first_nxt;
  logic [STAMP_W-1:0] second_r, second_nxt;
  stamp_res_t         res_r, res_nxt;
  logic [STAMP_W-1:0] ext;
  logic [STAMP_W-1:0] stamp;

  assign ext   = STAMP_W'(64'(ovf_r) << TIMER_BITS);
  assign stamp = STAMP_W'(capture_value & CAP_MASK) + ext;

  always_comb begin
    phase_nxt  = phase_r;
    ovf_nxt    = ovf_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    res_nxt    = res_r;
    if (accept) begin
      res_nxt = '0;
      if (!action) begin
        ovf_nxt = ovf_r + OVF_W'(1);
      end else begin
        unique case (phase_r)
          PH_FALL: begin
            second_nxt = stamp;
            phase_nxt  = PH_RISE2;
          end
          PH_RISE2: begin
            res_nxt.period = stamp - first_r;
            res_nxt.high   = second_r - first_r;
            res_nxt.done   = 1'b1;
            ovf_nxt        = '0;
            phase_nxt      = PH_RISE1;
          end
          default: begin
            first_nxt = stamp;
            phase_nxt = PH_FALL;
          end
        endcase
      end
      res_nxt.arm = (phase_nxt == PH_FALL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RISE1;
      ovf_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      ovf_r    <= ovf_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

FILE: design/pwmcm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module pwmcm_div #(
  parameter int NW = 39,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic [NW-1:0]      quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dq_r, dq_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, dq_r[NW-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule
`default_nettype wire

FILE: bench/pwm_capture_measure_top_tb.sv
// Self-checking bench for the PWM capture measurement top: stream stimulus and scoreboard.
`timescale 1ns / 100ps

class pwm_meas_board;
  typedef struct packed {
    logic        arm;
    logic        done;
    logic [31:0] period;
    logic [31:0] high;
    logic [6:0]  duty;
    logic [23:0] freq;
    logic        bad;
  } meas_t;

  meas_t               expected_meas_q[$];
  pwmcm_pkg::phase_t   phase;
  logic [15:0]         ovf_count;
  logic [31:0]         rise_stamp;
  logic [31:0]         fall_stamp;
  logic [23:0]         tick_rate;
  int                  mismatches;

  function new();
    phase      = pwmcm_pkg::PH_RISE1;
    ovf_count  = '0;
    rise_stamp = '0;
    fall_stamp = '0;
    tick_rate  = pwmcm_pkg::TICK_RATE_RST;
    mismatches = 0;
  endfunction

  function void set_rate(logic [23:0] rate);
    tick_rate = rate;
  endfunction

  function pwmcm_pkg::phase_t current_phase();
    return phase;
  endfunction

  function int outstanding();
    return expected_meas_q.size();
  endfunction

  function string fmt(meas_t m);
    return $sformatf("arm=%0d done=%0d period=%h high=%h duty=%0d freq=%0d bad=%0d",
                     m.arm, m.done, m.period, m.high, m.duty, m.freq, m.bad);
  endfunction

  function void predict_item(bit is_capture, logic [15:0] cap);
    meas_t       m;
    logic [31:0] stamp;
    logic [63:0] prod;
    logic [63:0] ratio;
    logic [31:0] freq_full;
    m = '0;
    if (!is_capture) begin
      ovf_count = ovf_count + 16'd1;
    end else begin
      stamp = {ovf_count, cap};
      case (phase)
        pwmcm_pkg::PH_FALL: begin
          fall_stamp = stamp;
          phase      = pwmcm_pkg::PH_RISE2;
        end
        pwmcm_pkg::PH_RISE2: begin
          m.period = stamp - rise_stamp;
          m.high   = fall_stamp - rise_stamp;
          if (m.period == 32'd0) begin
            m.bad = 1'b1;
          end else begin
            prod      = {32'd0, m.high} * 64'd100;
            ratio     = prod / {32'd0, m.period};
            m.duty    = (ratio > 64'd100) ? 7'd100 : ratio[6:0];
            freq_full = {8'd0, tick_rate} / m.period;
            m.freq    = freq_full[23:0];
          end
          m.done    = 1'b1;
          ovf_count = '0;
          phase     = pwmcm_pkg::PH_RISE1;
        end
        default: begin
          rise_stamp = stamp;
          phase      = pwmcm_pkg::PH_FALL;
        end
      endcase
    end
    m.arm = (phase == pwmcm_pkg::PH_FALL);
    expected_meas_q.push_back(m);
  endfunction

  function void check_measurement(logic [95:0] data, logic [1:0] user);
    meas_t got;
    meas_t want;
    got.arm    = data[0];
    got.period = data[32:1];
    got.high   = data[64:33];
    got.duty   = data[71:65];
    got.freq   = data[95:72];
    got.done   = user[0];
    got.bad    = user[1];
    if (expected_meas_q.size() == 0) begin
      mismatches = mismatches + 1;
      if (mismatches <= 10) $display("unexpected transfer: %s", fmt(got));
    end else begin
      want = expected_meas_q.pop_front();
      if (got !== want) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("mismatch expected: %s", fmt(want));
          $display("mismatch actual:   %s", fmt(got));
        end
      end
    end
  endfunction
endclass

module pwm_capture_measure_top_tb;
  import pwmcm_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 60;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [FREQ_W-1:0]     cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [CAP_W-1:0]      in_tdata    = '0;
  logic [0:0]            in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            quiet_cycles  = 0;
  int            n_sent        = 0;
  pwm_meas_board board;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pwm_capture_measure_top #(.TIMER_BITS(16)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_measurement(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input bit is_capture, input logic [15:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_capture;
    in_tdata  <= cap;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.predict_item(is_capture, cap);
    n_sent = n_sent + 1;
  endtask

  task automatic send_tick();
    send_item(1'b0, 16'($urandom));
  endtask

  task automatic send_capture(input logic [15:0] cap);
    send_item(1'b1, cap);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_tick_rate(input logic [23:0] rate);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_rate(rate);
  endtask

  function automatic logic [15:0] rand_cap();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(3) == 0) return $urandom_range(0, 3);
    return $urandom_range(4, 20000);
  endfunction

  task automatic send_measurement();
    int          marks [3];
    bit          realistic;
    logic [15:0] cap;
    realistic = $urandom_range(1);
    marks[0]  = $urandom_range(0, 20000);
    marks[1]  = marks[0] + rand_gap();
    marks[2]  = marks[1] + rand_gap();
    while (board.current_phase() != PH_RISE1) send_capture(rand_cap());
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) send_tick();
      cap = realistic ? 16'(marks[i]) : rand_cap();
      send_capture(cap);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_item(1'($urandom), rand_cap());
  endtask

  task automatic run_random(input int count);
    int start;
    bit paused;
    start  = n_sent;
    paused = 1'b0;
    while (n_sent - start < count) begin
      if (!paused && (n_sent - start >= count / 2)) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80) send_measurement();
      else send_noise();
    end
  endtask

  initial begin
    board = new();
    send_idle_pct = 29;
    recv_idle_pct = 80;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_tick();
    send_capture(16'h0000);
    send_capture(16'h0000);
    send_capture(16'h0000);
    send_capture(16'hFFFF);
    send_capture(16'h0000);
    send_capture(16'hFFFE);
    send_capture(16'h0100);
    send_capture(16'h0500);
    send_capture(16'h0200);
    send_capture(16'h0010);
    send_capture(16'h0011);
    send_capture(16'h0011);
    send_tick();
    send_capture(16'h8000);
    send_tick();
    send_capture(16'h0001);
    send_tick();
    send_capture(16'h0002);

    write_tick_rate(24'd16000000);
    run_random(270);

    send_idle_pct = 80;
    recv_idle_pct = 29;
    write_tick_rate(24'd1);
    send_capture(16'h1234);
    send_capture(16'h1234);
    send_capture(16'h1235);
    run_random(130);
    write_tick_rate(24'd0);
    run_random(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tick_rate(24'($urandom_range(1, 16000000)));
    run_random(270);

    while (board.current_phase() != PH_RISE1) send_capture(rand_cap());
    send_capture(16'h0100);
    for (int i = 0; i < 4; i++) send_tick();
    send_capture(16'h0200);
    send_capture(16'h0300);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: pwm_capture_measure_top.f
+incdir+design
design/pwmcm_pkg.sv
design/pwmcm_stamp.sv
design/pwmcm_div.sv
design/pwm_capture_measure_top.sv
bench/pwm_capture_measure_top_tb.sv
